// ----- sv/mfus_pkg.sv -----
// shared types and constants for the motor feedback unwrap and stall block
`default_nettype none

package mfus_pkg;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd4;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic KIND_SMALL   = 1'b0;
    localparam logic KIND_CURRENT = 1'b1;

    localparam logic signed [16:0] JUMP_HI = 17'sd4000;
    localparam logic signed [16:0] JUMP_LO = -17'sd4000;
    localparam logic signed [15:0] LAP_HI  = 16'sd32500;
    localparam logic signed [15:0] LAP_LO  = -16'sd32500;
    localparam logic        [15:0] TICK_MAX = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic        motor_kind;
        logic [15:0] error_limit;
        logic [15:0] speed_limit;
        logic [15:0] time_limit;
        logic [15:0] current_limit;
    } t_cfg;

    typedef struct packed {
        logic               is_check;
        logic signed [15:0] angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic               err_over;
    } t_item;

    typedef struct packed {
        logic signed [15:0] angle_out;
        logic signed [15:0] speed_out;
        logic signed [15:0] current_out;
        logic signed [15:0] lap_count;
        logic signed [31:0] unwrapped_angle;
        logic signed [31:0] target_angle;
        logic        [15:0] stall_count;
        logic               clear_integrators;
        logic               laps_reset;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/mfus_front.sv -----
// front end: takes input beats, decodes the opcode and precomputes the error test
`default_nettype none

module mfus_front (
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [mfus_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tuser,
    input  wire logic [15:0]                      i_error_limit,
    input  wire logic                             i_queue_full,
    output logic                                  o_push,
    output mfus_pkg::t_item                       o_item
);
    import mfus_pkg::*;

    logic signed [31:0] err;
    logic signed [32:0] err_ext;
    logic signed [32:0] lim_ext;

    assign err     = s_axis_tdata[79:48];
    assign err_ext = {err[31], err};
    assign lim_ext = $signed({17'b0, i_error_limit});

    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;

    always_comb begin
        o_item.is_check = (s_axis_tuser == OP_CHECK);
        o_item.angle    = s_axis_tdata[15:0];
        o_item.speed    = s_axis_tdata[31:16];
        o_item.current  = s_axis_tdata[47:32];
        o_item.err_over = (err_ext > lim_ext) || (err_ext < -lim_ext);
    end

endmodule

`default_nettype wire

// ----- sv/mfus_queue.sv -----
// two entry queue between the front end and the state update
`default_nettype none

module mfus_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  mfus_pkg::t_item      i_item,
    output logic                 o_full,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output mfus_pkg::t_item      o_item
);
    import mfus_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QPTR_W:0]    r_count;
    logic [QPTR_W:0]    n_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mfus_back.sv -----
// back end: unwrap state, stall rules and the output register
`default_nettype none

module mfus_back #(
    parameter int TURN_BITS = 13
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  mfus_pkg::t_cfg       i_cfg,
    input  wire logic            i_queue_empty,
    input  mfus_pkg::t_item      i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mfus_pkg::t_result    o_result
);
    import mfus_pkg::*;

    logic signed [15:0] r_last_angle;
    logic signed [15:0] r_last_speed;
    logic signed [15:0] r_last_current;
    logic signed [15:0] r_laps;
    logic signed [31:0] r_unwrapped;
    logic signed [31:0] r_target;
    logic        [15:0] r_ticks;
    logic               r_clr;
    logic               r_lreset;
    logic               r_valid;

    logic signed [15:0] n_last_current;
    logic signed [15:0] n_laps;
    logic signed [31:0] n_unwrapped;
    logic signed [31:0] n_target;
    logic        [15:0] n_ticks;
    logic               n_clr;
    logic               n_lreset;

    logic signed [16:0] step;
    logic signed [15:0] laps_step;
    logic               wrap;
    logic signed [15:0] laps_kept;
    logic        [31:0] lap_bits;
    logic        [16:0] spd_mag;
    logic        [16:0] cur_mag;
    logic               spd_slow;
    logic               cur_high;
    logic        [15:0] ticks_inc;

    assign o_pop   = !i_queue_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;

    // frame path
    always_comb begin
        step = {i_item.angle[15], i_item.angle} - {r_last_angle[15], r_last_angle};
        if (step < JUMP_LO) begin
            laps_step = r_laps + 16'sd1;
        end else if (step > JUMP_HI) begin
            laps_step = r_laps - 16'sd1;
        end else begin
            laps_step = r_laps;
        end
        wrap      = (laps_step > LAP_HI) || (laps_step < LAP_LO);
        laps_kept = wrap ? 16'sd0 : laps_step;
        lap_bits  = {{16{laps_kept[15]}}, laps_kept} << TURN_BITS;
    end

    // check path
    always_comb begin
        spd_mag   = r_last_speed[15] ? 17'(-{r_last_speed[15], r_last_speed})
                                     : {1'b0, r_last_speed};
        cur_mag   = r_last_current[15] ? 17'(-{r_last_current[15], r_last_current})
                                       : {1'b0, r_last_current};
        spd_slow  = spd_mag < {1'b0, i_cfg.speed_limit};
        cur_high  = cur_mag > {1'b0, i_cfg.current_limit};
        ticks_inc = (r_ticks != TICK_MAX) ? r_ticks + 16'd1 : r_ticks;
    end

    always_comb begin
        n_last_current = r_last_current;
        n_laps         = r_laps;
        n_unwrapped    = r_unwrapped;
        n_target       = r_target;
        n_ticks        = r_ticks;
        n_clr          = 1'b0;
        n_lreset       = 1'b0;
        if (!i_item.is_check) begin
            if (i_cfg.motor_kind == KIND_CURRENT) begin
                n_last_current = i_item.current;
            end
            n_laps      = laps_kept;
            n_unwrapped = $signed(lap_bits + {{16{i_item.angle[15]}}, i_item.angle});
            if (wrap) begin
                n_target = {{16{i_item.angle[15]}}, i_item.angle};
                n_lreset = 1'b1;
            end
        end else begin
            if (i_cfg.motor_kind == KIND_SMALL) begin
                if (i_item.err_over && spd_slow) begin
                    if (ticks_inc > i_cfg.time_limit) begin
                        n_clr   = 1'b1;
                        n_ticks = '0;
                    end else begin
                        n_ticks = ticks_inc;
                    end
                end else begin
                    n_ticks = '0;
                end
            end else begin
                n_clr = spd_slow && cur_high;
            end
            if (n_clr) begin
                n_target = r_unwrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle   <= '0;
            r_last_speed   <= '0;
            r_last_current <= '0;
            r_laps         <= '0;
            r_unwrapped    <= '0;
            r_target       <= '0;
            r_ticks        <= '0;
            r_clr          <= 1'b0;
            r_lreset       <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            if (o_pop) begin
                if (!i_item.is_check) begin
                    r_last_angle <= i_item.angle;
                    r_last_speed <= i_item.speed;
                end
                r_last_current <= n_last_current;
                r_laps         <= n_laps;
                r_unwrapped    <= n_unwrapped;
                r_target       <= n_target;
                r_ticks        <= n_ticks;
                r_clr          <= n_clr;
                r_lreset       <= n_lreset;
                r_valid        <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_result.angle_out         = r_last_angle;
        o_result.speed_out         = r_last_speed;
        o_result.current_out       = r_last_current;
        o_result.lap_count         = r_laps;
        o_result.unwrapped_angle   = r_unwrapped;
        o_result.target_angle      = r_target;
        o_result.stall_count       = r_ticks;
        o_result.clear_integrators = r_clr;
        o_result.laps_reset        = r_lreset;
    end

endmodule

`default_nettype wire

// ----- sv/motor_feedback_unwrap_stall_core.sv -----
// top level of the motor feedback unwrap and stall block
//
// input stream: one beat per item; s_axis_tuser selects a feedback frame (0)
// or a stall check tick (1); s_axis_tdata carries angle, speed, current and
// position error. output stream: one beat per input beat, in order, with the
// stored angle, speed, current, lap count, unwrapped angle, target, stall
// count and the clear and lap reset flags.
// config channel: i_cfg_valid with i_cfg_index and i_cfg_data; always ready.
// the user keeps it written only while no item is in flight; the block does
// not enforce this. an accepted beat passes through the queue and then the
// back end output register before it shows on m_axis. throughput: one beat
// per cycle while the receiver keeps up, set by the state update in the back
// end that feeds the next item's unwrap step. a two beat queue sits between
// the input side and the state update; when the receiver stalls the output
// beat holds, the queue fills and s_axis_tready drops after two more beats.
// reset clears all state to zero, sets motor kind to 1 and empties the queue.
`default_nettype none

module motor_feedback_unwrap_stall_core #(
    parameter int TURN_BITS = 13
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // angle_raw, speed_raw, current_raw, position_error
    input  wire logic [mfus_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // angle_out, speed_out, current_out, lap_count, unwrapped_angle,
    // target_angle, stall_count, clear_integrators, laps_reset, zero pad
    output logic [mfus_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mfus_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mfus_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mfus_pkg::*;

    t_cfg    r_cfg;
    t_item   front_item;
    t_item   queue_item;
    t_result result;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motor_kind    <= KIND_CURRENT;
            r_cfg.error_limit   <= '0;
            r_cfg.speed_limit   <= '0;
            r_cfg.time_limit    <= '0;
            r_cfg.current_limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MOTOR_KIND:    r_cfg.motor_kind    <= i_cfg_data[0];
                REG_ERROR_LIMIT:   r_cfg.error_limit   <= i_cfg_data;
                REG_SPEED_LIMIT:   r_cfg.speed_limit   <= i_cfg_data;
                REG_TIME_LIMIT:    r_cfg.time_limit    <= i_cfg_data;
                REG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfus_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_error_limit (r_cfg.error_limit),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    mfus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .i_pop   (pop),
        .o_item  (queue_item)
    );

    mfus_back #(
        .TURN_BITS (TURN_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_empty (queue_empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (result)
    );

    assign m_axis_tdata = {6'b0,
                           result.laps_reset,
                           result.clear_integrators,
                           result.stall_count,
                           result.target_angle,
                           result.unwrapped_angle,
                           result.lap_count,
                           result.current_out,
                           result.speed_out,
                           result.angle_out};

endmodule

`default_nettype wire

// ----- sv/mfus_checker.sv -----
// port level checks for the motor feedback unwrap and stall block
`default_nettype none

module mfus_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_m_tvalid,
    input wire logic          i_m_tready,
    input wire logic [151:0]  i_m_tdata
);

    logic signed [15:0] lap;
    logic signed [15:0] ang;
    logic        [31:0] unw;
    logic        [31:0] tgt;
    logic               clr;
    logic               lrst;

    assign ang  = i_m_tdata[15:0];
    assign lap  = i_m_tdata[63:48];
    assign unw  = i_m_tdata[95:64];
    assign tgt  = i_m_tdata[127:96];
    assign clr  = i_m_tdata[144];
    assign lrst = i_m_tdata[145];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output beat changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(clr && lrst))
        else $error("clear and lap reset on one beat");

    a_lap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (lap <= 16'sd32500) && (lap >= -16'sd32500))
        else $error("lap count out of range");

    a_clr_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && clr |-> tgt == unw)
        else $error("stall clear without target at unwrapped angle");

    a_lap_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && lrst |-> lap == 16'sd0 && tgt == {{16{ang[15]}}, ang})
        else $error("lap reset without zero laps and target at raw angle");

endmodule

bind motor_feedback_unwrap_stall_core mfus_checker u_mfus_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/motor_feedback_unwrap_stall_checker.sv -----
// checker for the motor feedback unwrap and stall block: prediction and comparison
`timescale 1ns / 1ps

module motor_feedback_unwrap_stall_checker
    import mfus_pkg::*;
#(
    parameter int TURN_BITS = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  i_s_axis_tready,
    // angle_raw, speed_raw, current_raw, position_error
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  wire logic                  i_s_axis_tuser,
    input  wire logic                  i_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // angle_out, speed_out, current_out, lap_count, unwrapped_angle,
    // target_angle, stall_count, clear_integrators, laps_reset, zero pad
    input  wire logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic               cfg_kind;
    logic [15:0]        cfg_err_lim;
    logic [15:0]        cfg_spd_lim;
    logic [15:0]        cfg_time_lim;
    logic [15:0]        cfg_cur_lim;

    logic signed [15:0] rotor_angle;
    logic signed [15:0] rotor_speed;
    logic signed [15:0] rotor_current;
    int                 lap_total;
    logic [31:0]        unwrap_acc;
    logic [31:0]        target_pos;
    logic [15:0]        tick_count;

    t_result            feedback_q[$];
    int                 mismatches = 0;

    task automatic clear_model();
        cfg_kind = KIND_CURRENT;
        cfg_err_lim = '0;
        cfg_spd_lim = '0;
        cfg_time_lim = '0;
        cfg_cur_lim = '0;
        rotor_angle = '0;
        rotor_speed = '0;
        rotor_current = '0;
        lap_total = 0;
        unwrap_acc = '0;
        target_pos = '0;
        tick_count = '0;
        feedback_q.delete();
    endtask

    function automatic int mag16(logic signed [15:0] v);
        return v < 0 ? -int'(v) : int'(v);
    endfunction

    task automatic predict_beat(input logic op, input logic [IN_DATA_W-1:0] d,
                                output t_result r);
        logic signed [15:0] prev;
        int                 jump;
        longint             err;
        logic               clr;
        logic               wrapped;
        clr = 1'b0;
        wrapped = 1'b0;
        if (op == OP_FRAME) begin
            prev = rotor_angle;
            rotor_angle = $signed(d[15:0]);
            rotor_speed = $signed(d[31:16]);
            if (cfg_kind == KIND_CURRENT)
                rotor_current = $signed(d[47:32]);
            jump = int'(rotor_angle) - int'(prev);
            if (jump < int'(JUMP_LO))
                lap_total++;
            else if (jump > int'(JUMP_HI))
                lap_total--;
            if (lap_total > int'(LAP_HI) || lap_total < int'(LAP_LO)) begin
                lap_total = 0;
                target_pos = 32'(int'(rotor_angle));
                wrapped = 1'b1;
            end
            unwrap_acc = (32'(lap_total) << TURN_BITS) + 32'(int'(rotor_angle));
        end else begin
            if (cfg_kind == KIND_SMALL) begin
                err = longint'($signed(d[79:48]));
                if (err < 0)
                    err = -err;
                if (err > longint'(cfg_err_lim) && mag16(rotor_speed) < int'(cfg_spd_lim)) begin
                    if (tick_count != TICK_MAX)
                        tick_count++;
                    if (tick_count > cfg_time_lim) begin
                        clr = 1'b1;
                        tick_count = '0;
                    end
                end else begin
                    tick_count = '0;
                end
            end else if (mag16(rotor_speed) < int'(cfg_spd_lim) &&
                         mag16(rotor_current) > int'(cfg_cur_lim)) begin
                clr = 1'b1;
            end
            if (clr)
                target_pos = unwrap_acc;
        end
        r.angle_out = rotor_angle;
        r.speed_out = rotor_speed;
        r.current_out = rotor_current;
        r.lap_count = 16'(lap_total);
        r.unwrapped_angle = unwrap_acc;
        r.target_angle = target_pos;
        r.stall_count = tick_count;
        r.clear_integrators = clr;
        r.laps_reset = wrapped;
    endtask

    function automatic t_result split_beat(logic [OUT_DATA_W-1:0] d);
        t_result r;
        r.angle_out = d[15:0];
        r.speed_out = d[31:16];
        r.current_out = d[47:32];
        r.lap_count = d[63:48];
        r.unwrapped_angle = d[95:64];
        r.target_angle = d[127:96];
        r.stall_count = d[143:128];
        r.clear_integrators = d[144];
        r.laps_reset = d[145];
        return r;
    endfunction

    task automatic flag(string msg);
        if (mismatches < 10)
            $display("%0t: mismatch, %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
            flag($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_result got_r;
        t_result want_r;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r = split_beat(i_m_axis_tdata);
                if (feedback_q.size() == 0) begin
                    flag("result beat with nothing pending");
                end else begin
                    want_r = feedback_q.pop_front();
                    check_field("angle_out", 32'(want_r.angle_out), 32'(got_r.angle_out));
                    check_field("speed_out", 32'(want_r.speed_out), 32'(got_r.speed_out));
                    check_field("current_out", 32'(want_r.current_out),
                                32'(got_r.current_out));
                    check_field("lap_count", 32'(want_r.lap_count), 32'(got_r.lap_count));
                    check_field("unwrapped_angle", want_r.unwrapped_angle,
                                got_r.unwrapped_angle);
                    check_field("target_angle", want_r.target_angle, got_r.target_angle);
                    check_field("stall_count", 32'(want_r.stall_count),
                                32'(got_r.stall_count));
                    check_field("clear_integrators", 32'(want_r.clear_integrators),
                                32'(got_r.clear_integrators));
                    check_field("laps_reset", 32'(want_r.laps_reset),
                                32'(got_r.laps_reset));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MOTOR_KIND:    cfg_kind = i_cfg_data[0];
                    REG_ERROR_LIMIT:   cfg_err_lim = i_cfg_data;
                    REG_SPEED_LIMIT:   cfg_spd_lim = i_cfg_data;
                    REG_TIME_LIMIT:    cfg_time_lim = i_cfg_data;
                    REG_CURRENT_LIMIT: cfg_cur_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_beat(i_s_axis_tuser, i_s_axis_tdata, want_r);
                feedback_q.push_back(want_r);
            end
        end
        o_pending <= feedback_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the motor feedback unwrap and stall block: stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import mfus_pkg::*;

    localparam int TURN_BITS      = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 210;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int                    fail_count;
    int                    pending;
    logic                  calm;
    int                    hold_len;
    logic [15:0]           last_sent_angle;

    motor_feedback_unwrap_stall_core #(
        .TURN_BITS(TURN_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    motor_feedback_unwrap_stall_checker #(
        .TURN_BITS(TURN_BITS)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random back-pressure plus requested long hold-offs
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (hold_len > 0) begin
                m_axis_tready = 1'b0;
                stall_left = hold_len - 1;
                hold_len = 0;
            end else begin
                m_axis_tready = calm || $urandom_range(0, 99) >= 24;
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic push_item(input logic op, input logic [IN_DATA_W-1:0] d);
        while (!calm && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = d;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] ang, input logic [15:0] spd,
                              input logic [15:0] cur);
        last_sent_angle = ang;
        push_item(OP_FRAME, {32'($urandom), cur, spd, ang});
    endtask

    task automatic send_check(input logic [31:0] perr);
        push_item(OP_CHECK, {perr, 16'($urandom), 32'($urandom)});
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_setup(input logic kind, input logic [15:0] err_lim,
                               input logic [15:0] spd_lim, input logic [15:0] time_lim,
                               input logic [15:0] cur_lim);
        settle();
        write_reg(REG_MOTOR_KIND, {15'($urandom), kind});
        write_reg(REG_ERROR_LIMIT, err_lim);
        write_reg(REG_SPEED_LIMIT, spd_lim);
        write_reg(REG_TIME_LIMIT, time_lim);
        write_reg(REG_CURRENT_LIMIT, cur_lim);
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near_zero16();
        return 16'($urandom_range(0, 400)) - 16'd200;
    endfunction

    task automatic random_item();
        logic [15:0] ang;
        logic [15:0] jump;
        if ($urandom_range(0, 99) < 45) begin
            if ($urandom_range(0, 1))
                send_check(32'($urandom));
            else
                send_check(32'($urandom_range(0, 140000)) - 32'd70000);
        end else begin
            case ($urandom_range(0, 3))
                0: ang = 16'($urandom);
                1: ang = last_sent_angle + 16'($urandom_range(0, 10000)) - 16'd5000;
                2: begin
                    jump = 16'(JUMP_HI) + 16'($urandom_range(0, 1));
                    ang = $urandom_range(0, 1) ? last_sent_angle + jump
                                               : last_sent_angle - jump;
                end
                default: ang = last_sent_angle + near_zero16();
            endcase
            send_frame(ang, $urandom_range(0, 1) ? near_zero16() : 16'($urandom),
                       $urandom_range(0, 1) ? near_zero16() : 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] tlim;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_FRAME;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MOTOR_KIND;
        i_cfg_data = '0;
        calm = 1'b0;
        hold_len = 0;
        last_sent_angle = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: current kind, all limits zero
        send_frame(16'h0000, 16'h0000, 16'h0000);
        send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_frame(16'h8000, 16'h8000, 16'h8000);
        send_check(32'h7FFF_FFFF);
        apply_setup(KIND_CURRENT, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        for (int k = int'(REG_CURRENT_LIMIT) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), 16'hFFFF);
        send_check(32'h0000_0000);
        send_frame(16'd100, 16'hFFFF, 16'h8000);
        send_check(32'hFFFF_FFFF);

        // small motor: jump thresholds and a zero time limit
        apply_setup(KIND_SMALL, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_frame(16'd4100, 16'd0, 16'd12345);
        send_frame(16'd100, 16'd0, 16'd1);
        send_frame(-16'sd3901, 16'd5, 16'd0);
        send_frame(16'd100, 16'd5, 16'd0);
        send_check(32'h8000_0000);
        send_check(32'h0000_0000);
        send_check(32'h0000_0001);
        apply_setup(KIND_SMALL, 16'hFFFF, 16'h0001, 16'h0002, 16'h0000);
        send_frame(16'd0, 16'd0, 16'd0);
        send_check(-32'sd65536);
        send_check(32'd65535);
        send_check(32'h7FFF_FFFF);
        send_check(32'h8000_0000);
        send_check(32'hFFFF_0000);
        send_frame(16'd0, 16'hFFFF, 16'd0);
        send_check(32'h8000_0000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tlim = $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 6)) : pick_limit();
            apply_setup(1'($urandom_range(0, 1)), pick_limit(), pick_limit(), tlim,
                        pick_limit());
            calm = (ph == 0 || ph == 3);
            if (ph == 3)
                hold_len = 80;
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_item();
            calm = 1'b0;
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
